[rtl/core/lock_order_cycle_detector_macros.svh]
// Assertion macros for the top level of the lock order cycle detector RTL.
`ifndef LOCK_ORDER_CYCLE_DETECTOR_MACROS_SVH
`define LOCK_ORDER_CYCLE_DETECTOR_MACROS_SVH
`ifndef SYNTH
`define LOCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LOCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LOCD_ASSERT_NOW(lbl, ante, cons, msg)
`define LOCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/locd_pkg.sv]
// Shared types and constants of the lock order cycle detector.
package locd_pkg;

    localparam int MAX_LOCKS_DEF   = 16;
    localparam int MAX_THREADS_DEF = 4;
    localparam int STACK_DEPTH_DEF = 16;

    localparam int STATUS_W = 3;
    localparam int THREAD_W = 2;
    localparam int LOCK_W   = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_DEADLOCK = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_HALTED   = 3'd5
    } status_t;

    typedef struct packed {
        logic    accept;
        logic    push;
        logic    pop_held;
        logic    add_edge;
        logic    dfs_init;
        logic    root_next;
        logic    root_start;
        logic    visit;
        logic    retire;
        logic    pop_load;
        logic    load_result;
        status_t result;
    } locd_cmd_t;

    typedef struct packed {
        logic halted;
        logic is_release;
        logic depth_zero;
        logic depth_full;
        logic edge_new;
        logic mismatch;
        logic root_visited;
        logic root_last;
        logic cand_found;
        logic cand_visited;
        logic path_single;
        logic out_free;
    } locd_sts_t;

endpackage

[rtl/core/lock_order_cycle_detector.sv]
// Top level of the lock order cycle detector.
// Each transaction is an acquire or release of a lock by a thread and yields one status
// transaction. Releases, repeated holds, known edges and errors pass through accept,
// held-stack RAM fetch and result load, plus any output stall. An acquire that adds a new
// order edge runs a depth-first search over the whole graph in one shared sequencer that
// reads one adjacency row per cycle: setup, a check of each root (up to MAX_LOCKS), entry
// of each node, and retire and pop of each node through the search stack RAM. After any
// error the block reports halted for every later transaction. The order matrix resets at
// once.
`include "lock_order_cycle_detector_macros.svh"

module lock_order_cycle_detector #(
    parameter int MAX_LOCKS   = locd_pkg::MAX_LOCKS_DEF,
    parameter int MAX_THREADS = locd_pkg::MAX_THREADS_DEF,
    parameter int STACK_DEPTH = locd_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [locd_pkg::THREAD_W-1:0] thread_id,
    input  logic [locd_pkg::LOCK_W-1:0]   lock_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [locd_pkg::STATUS_W-1:0] status,
    output logic                          new_edge
);

    locd_pkg::locd_cmd_t cmd;
    locd_pkg::locd_sts_t sts;
    logic                edge_status_ok;

    locd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    locd_datapath #(
        .MAX_LOCKS  (MAX_LOCKS),
        .MAX_THREADS(MAX_THREADS),
        .STACK_DEPTH(STACK_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .thread_id(thread_id),
        .lock_id  (lock_id),
        .cmd      (cmd),
        .sts      (sts),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .new_edge (new_edge)
    );

    assign edge_status_ok = (status == locd_pkg::ST_OK) || (status == locd_pkg::ST_DEADLOCK);

    `LOCD_ASSERT_NEXT(a_accept_stalls, in_valid && !in_stall, in_stall, "no stall after accept")
    `LOCD_ASSERT_NEXT(a_halt_sticky, sts.halted, sts.halted, "halt flag cleared")
    `LOCD_ASSERT_NOW(a_load_free, cmd.load_result, !out_valid || !out_stall, "result overrun")
    `LOCD_ASSERT_NOW(a_edge_status, out_valid && new_edge, edge_status_ok, "bad edge status")

endmodule

[rtl/core/locd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module locd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/locd_datapath.sv]
// Datapath: held-lock stacks, order edge matrix, search state and result register.
module locd_datapath #(
    parameter int MAX_LOCKS   = locd_pkg::MAX_LOCKS_DEF,
    parameter int MAX_THREADS = locd_pkg::MAX_THREADS_DEF,
    parameter int STACK_DEPTH = locd_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          mode,
    input  logic [locd_pkg::THREAD_W-1:0] thread_id,
    input  logic [locd_pkg::LOCK_W-1:0]   lock_id,
    input  locd_pkg::locd_cmd_t           cmd,
    output locd_pkg::locd_sts_t           sts,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [locd_pkg::STATUS_W-1:0] status,
    output logic                          new_edge
);

    localparam int LW    = $clog2(MAX_LOCKS);
    localparam int TW    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int DW    = $clog2(STACK_DEPTH + 1);
    localparam int HD    = MAX_THREADS * STACK_DEPTH;
    localparam int HAW   = (HD > 1) ? $clog2(HD) : 1;
    localparam int TOPW  = $clog2(MAX_LOCKS + 1);

    function automatic logic [TW-1:0] thr_index(input logic [locd_pkg::THREAD_W-1:0] v);
        int r;
        r = int'(v);
        for (int i = 0; i < 4; i++)
        begin
            if (r >= MAX_THREADS)
            begin
                r = r - MAX_THREADS;
            end
        end
        return TW'(r);
    endfunction

    function automatic logic [LW-1:0] lock_index(input logic [locd_pkg::LOCK_W-1:0] v);
        int r;
        r = int'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= MAX_LOCKS)
            begin
                r = r - MAX_LOCKS;
            end
        end
        return LW'(r);
    endfunction

    function automatic logic [HAW-1:0] held_base(input logic [TW-1:0] t);
        return HAW'(HAW'(t) * HAW'(STACK_DEPTH));
    endfunction

    logic                   mode_reg;
    logic [TW-1:0]          thr_reg;
    logic [LW-1:0]          lock_reg;
    logic                   added_reg;
    logic                   halted_reg;
    logic [DW-1:0]          depth_reg [MAX_THREADS];
    logic [MAX_LOCKS-1:0]   edges_reg [MAX_LOCKS];
    logic [MAX_LOCKS-1:0]   visited_reg;
    logic [MAX_LOCKS-1:0]   finished_reg;
    logic [LW-1:0]          root_reg;
    logic [LW-1:0]          here_reg;
    logic [TOPW-1:0]        top_reg;
    logic                   out_valid_reg;
    locd_pkg::status_t      status_reg;
    logic                   new_edge_reg;

    logic [TW-1:0]          thr_in;
    logic [DW-1:0]          depth_in;
    logic [DW-1:0]          depth_cur;
    logic [HAW-1:0]         held_rd_addr;
    logic [HAW-1:0]         held_wr_addr;
    logic [LW-1:0]          held_rd_data;
    logic [LW-1:0]          srch_wr_addr;
    logic [LW-1:0]          srch_wr_data;
    logic [LW-1:0]          srch_rd_addr;
    logic [LW-1:0]          srch_rd_data;
    logic [MAX_LOCKS-1:0]   cand;
    logic [LW-1:0]          cand_idx;
    logic                   out_free;

    assign thr_in       = thr_index(thread_id);
    assign depth_in     = depth_reg[thr_in];
    assign depth_cur    = depth_reg[thr_reg];
    // Address of the top entry of the incoming thread; read lands in the fetch cycle.
    assign held_rd_addr = held_base(thr_in) + HAW'(depth_in - DW'(1));
    assign held_wr_addr = held_base(thr_reg) + HAW'(depth_cur);

    locd_ram #(
        .WIDTH(LW),
        .DEPTH(HD)
    ) u_held_ram (
        .clk    (clk),
        .wr_en  (cmd.push),
        .wr_addr(held_wr_addr),
        .wr_data(lock_reg),
        .rd_addr(held_rd_addr),
        .rd_data(held_rd_data)
    );

    assign srch_wr_addr = cmd.visit ? top_reg[LW-1:0] : '0;
    assign srch_wr_data = cmd.visit ? cand_idx : root_reg;
    assign srch_rd_addr = LW'(top_reg - TOPW'(2));

    locd_ram #(
        .WIDTH(LW),
        .DEPTH(MAX_LOCKS)
    ) u_search_ram (
        .clk    (clk),
        .wr_en  (cmd.visit | cmd.root_start),
        .wr_addr(srch_wr_addr),
        .wr_data(srch_wr_data),
        .rd_addr(srch_rd_addr),
        .rd_data(srch_rd_data)
    );

    assign cand = edges_reg[here_reg] & ~finished_reg;

    always_comb
    begin
        cand_idx = '0;
        for (int i = MAX_LOCKS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                cand_idx = LW'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.halted       = halted_reg;
    assign sts.is_release   = mode_reg;
    assign sts.depth_zero   = (depth_cur == '0);
    assign sts.depth_full   = (depth_cur == DW'(STACK_DEPTH));
    assign sts.edge_new     = (held_rd_data != lock_reg) && !edges_reg[held_rd_data][lock_reg];
    assign sts.mismatch     = (held_rd_data != lock_reg);
    assign sts.root_visited = visited_reg[root_reg];
    assign sts.root_last    = (root_reg == LW'(MAX_LOCKS - 1));
    assign sts.cand_found   = |cand;
    assign sts.cand_visited = visited_reg[cand_idx];
    assign sts.path_single  = (top_reg == TOPW'(1));
    assign sts.out_free     = out_free;

    // Transaction fields and search bookkeeping; no reset needed on payload.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            thr_reg  <= thr_in;
            lock_reg <= lock_index(lock_id);
        end
        if (cmd.dfs_init)
        begin
            root_reg <= '0;
        end
        else if (cmd.root_next)
        begin
            root_reg <= root_reg + LW'(1);
        end
        if (cmd.root_start)
        begin
            here_reg <= root_reg;
            top_reg  <= TOPW'(1);
        end
        else if (cmd.visit)
        begin
            here_reg <= cand_idx;
            top_reg  <= top_reg + TOPW'(1);
        end
        else if (cmd.retire)
        begin
            top_reg <= top_reg - TOPW'(1);
        end
        else if (cmd.pop_load)
        begin
            here_reg <= srch_rd_data;
        end
        if (cmd.load_result)
        begin
            status_reg   <= cmd.result;
            new_edge_reg <= added_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            added_reg     <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            visited_reg   <= '0;
            finished_reg  <= '0;
            for (int t = 0; t < MAX_THREADS; t++)
            begin
                depth_reg[t] <= '0;
            end
            for (int r = 0; r < MAX_LOCKS; r++)
            begin
                edges_reg[r] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                added_reg <= 1'b0;
            end
            else if (cmd.add_edge)
            begin
                added_reg <= 1'b1;
                edges_reg[held_rd_data][lock_reg] <= 1'b1;
            end
            if (cmd.push)
            begin
                depth_reg[thr_reg] <= depth_cur + DW'(1);
            end
            else if (cmd.pop_held)
            begin
                depth_reg[thr_reg] <= depth_cur - DW'(1);
            end
            if (cmd.dfs_init)
            begin
                visited_reg  <= '0;
                finished_reg <= '0;
            end
            else
            begin
                if (cmd.root_start)
                begin
                    visited_reg[root_reg] <= 1'b1;
                end
                if (cmd.visit)
                begin
                    visited_reg[cand_idx] <= 1'b1;
                end
                if (cmd.retire)
                begin
                    finished_reg[here_reg] <= 1'b1;
                end
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
                if (cmd.result != locd_pkg::ST_OK && cmd.result != locd_pkg::ST_HALTED)
                begin
                    halted_reg <= 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign new_edge  = new_edge_reg;

endmodule

[rtl/core/locd_ctrl.sv]
// Controller: sequences fetch, stack update, cycle search and result hand-off.
module locd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  locd_pkg::locd_sts_t sts,
    output locd_pkg::locd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DFS_INIT,
        S_ROOT,
        S_SCAN,
        S_POP,
        S_FINISH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    locd_pkg::status_t code_reg;
    locd_pkg::status_t code_next;
    logic              stall_reg;
    logic              stall_next;

    always_comb
    begin
        cmd        = '0;
        cmd.result = code_reg;
        state_next = state_reg;
        code_next  = code_reg;
        stall_next = stall_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    stall_next = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_FINISH;
                code_next  = locd_pkg::ST_OK;
                priority if (sts.halted)
                begin
                    code_next = locd_pkg::ST_HALTED;
                end
                else if (sts.is_release)
                begin
                    priority if (sts.depth_zero)
                    begin
                        code_next = locd_pkg::ST_EMPTY;
                    end
                    else if (sts.mismatch)
                    begin
                        code_next = locd_pkg::ST_MISMATCH;
                    end
                    else
                    begin
                        cmd.pop_held = 1'b1;
                    end
                end
                else if (sts.depth_full)
                begin
                    code_next = locd_pkg::ST_OVERFLOW;
                end
                else if (!sts.depth_zero && sts.edge_new)
                begin
                    cmd.add_edge = 1'b1;
                    state_next   = S_DFS_INIT;
                end
                else
                begin
                    cmd.push = 1'b1;
                end
            end
            S_DFS_INIT:
            begin
                cmd.dfs_init = 1'b1;
                state_next   = S_ROOT;
            end
            S_ROOT:
            begin
                priority if (!sts.root_visited)
                begin
                    cmd.root_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (sts.root_last)
                begin
                    cmd.push   = 1'b1;
                    code_next  = locd_pkg::ST_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.root_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                priority if (sts.cand_found && sts.cand_visited)
                begin
                    // Back edge to a node on the current path: true cycle.
                    code_next  = locd_pkg::ST_DEADLOCK;
                    state_next = S_FINISH;
                end
                else if (sts.cand_found)
                begin
                    cmd.visit = 1'b1;
                end
                else
                begin
                    cmd.retire = 1'b1;
                    priority if (!sts.path_single)
                    begin
                        state_next = S_POP;
                    end
                    else if (sts.root_last)
                    begin
                        cmd.push   = 1'b1;
                        code_next  = locd_pkg::ST_OK;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.root_next = 1'b1;
                        state_next    = S_ROOT;
                    end
                end
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_SCAN;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    stall_next      = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= locd_pkg::ST_OK;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

endmodule
